// ===== design/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg: shared types and constants of the segment intersection classifier
// Angle table, configuration indexes and junction kind codes.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int TAB_FRAC     = 20;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 42;
  localparam int ACC_W        = 30;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;
  localparam int FW_W       = 11;
  localparam int FH_W       = 10;
  localparam int ND_W       = 8;
  localparam int MA_W       = 8;

  localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = ACC_W'(180 * (1 << TAB_FRAC));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 8'd0,
    CFG_FRAME_HEIGHT = 8'd1,
    CFG_NEAR_DIST    = 8'd2,
    CFG_MIN_ANGLE    = 8'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_CROSS  = 2'd0,
    KIND_TEE    = 2'd1,
    KIND_CORNER = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // atan(2^-k) in units of 2^-20 degree
  function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned k);
    case (k)
      0:  return ACC_W'(47185920);
      1:  return ACC_W'(27855475);
      2:  return ACC_W'(14718068);
      3:  return ACC_W'(7471121);
      4:  return ACC_W'(3750058);
      5:  return ACC_W'(1876857);
      6:  return ACC_W'(938658);
      7:  return ACC_W'(469357);
      8:  return ACC_W'(234682);
      9:  return ACC_W'(117342);
      10: return ACC_W'(58671);
      11: return ACC_W'(29335);
      12: return ACC_W'(14668);
      13: return ACC_W'(7334);
      14: return ACC_W'(3667);
      15: return ACC_W'(1833);
      16: return ACC_W'(917);
      17: return ACC_W'(458);
      18: return ACC_W'(229);
      19: return ACC_W'(115);
      20: return ACC_W'(57);
      21: return ACC_W'(29);
      22: return ACC_W'(14);
      23: return ACC_W'(7);
      default: return '0;
    endcase
  endfunction

endpackage

// ===== design/segment_intersection_classifier.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_classifier: intersection point and junction kind
// of two pixel segments
// The result path runs through the divider (3*COORD_BITS+7 stages) and the
// square root pipeline (COORD_BITS+1+ROOT_FRAC_BITS).
// Throughput one beat per cycle; busy never rises and results cannot stall.
// Reset clears the valid bits and loads the register defaults 800, 448, 50, 15.
// ----------------------------------------------------------------------------
module segment_intersection_classifier #(
  parameter int COORD_BITS      = 10,
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int ROOT_FRAC_BITS  = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_BITS-1:0]           first_start_x_i,
  input  logic [COORD_BITS-2:0]           first_start_y_i,
  input  logic [COORD_BITS-1:0]           first_end_x_i,
  input  logic [COORD_BITS-2:0]           first_end_y_i,
  input  logic [COORD_BITS-1:0]           second_start_x_i,
  input  logic [COORD_BITS-2:0]           second_start_y_i,
  input  logic [COORD_BITS-1:0]           second_end_x_i,
  input  logic [COORD_BITS-2:0]           second_end_y_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sic_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sic_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            result_valid_o,
  output logic [COORD_BITS-1:0]           cross_x_o,
  output logic [COORD_BITS-2:0]           cross_y_o,
  output logic                            found_o,
  output logic [1:0]                      kind_o
);
  import sic_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int PW   = 2 * DW + 1;
  localparam int NW   = DW + PW;
  localparam int QW   = NW + 2;
  localparam int RXW  = QW + 1;
  localparam int LC   = CORDIC_STEPS + 2;
  localparam int LD   = NW + 3;
  localparam int SW   = 2 * C + 1 + 2 * ROOT_FRAC_BITS;
  localparam int RB   = (SW + 1) / 2;
  localparam int ES   = RB + 2;
  localparam int T_Q  = 4 + LD;
  localparam int T_A  = LC + 2;
  localparam int NV   = T_Q + 6 + RB;
  localparam int XLW  = (C + 1 > FW_W) ? C + 1 : FW_W;
  localparam int YLW  = (C > FH_W) ? C : FH_W;
  localparam int NEAR_W = ND_W + ROOT_FRAC_BITS;
  localparam logic [XLW-1:0] XLIM = XLW'(1) << C;
  localparam logic [YLW-1:0] YLIM = YLW'(1) << (C - 1);

  typedef struct packed {
    logic [C-1:0] s1ox;
    logic [C-2:0] s1oy;
    logic [C-1:0] s1px;
    logic [C-2:0] s1py;
    logic [C-1:0] s2ox;
    logic [C-2:0] s2oy;
    logic [C-1:0] s2px;
    logic [C-2:0] s2py;
  } seg_t;

  typedef struct packed {
    logic [C-1:0] ix;
    logic [C-2:0] iy;
    logic         fnd;
  } res_t;

  // configuration
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [ND_W-1:0] nd_q;
  logic [MA_W-1:0] ma_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_W'(800);
      fh_q <= FH_W'(448);
      nd_q <= ND_W'(50);
      ma_q <= MA_W'(15);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
        CFG_NEAR_DIST:    nd_q <= cfg_data_i[ND_W-1:0];
        CFG_MIN_ANGLE:    ma_q <= cfg_data_i[MA_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits
  logic [NV-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NV-2:0], start && !busy};
    end
  end

  // input beat
  seg_t seg_q;

  always_ff @(posedge clk_i) begin
    seg_q <= {first_start_x_i, first_start_y_i, first_end_x_i, first_end_y_i,
              second_start_x_i, second_start_y_i, second_end_x_i, second_end_y_i};
  end

  // direction vectors
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, ex_q, ey_q;

  always_ff @(posedge clk_i) begin
    d1x_q <= DW'(seg_q.s1px) - DW'(seg_q.s1ox);
    d1y_q <= DW'(seg_q.s1py) - DW'(seg_q.s1oy);
    d2x_q <= DW'(seg_q.s2px) - DW'(seg_q.s2ox);
    d2y_q <= DW'(seg_q.s2py) - DW'(seg_q.s2oy);
    ex_q  <= DW'(seg_q.s2ox) - DW'(seg_q.s1ox);
    ey_q  <= DW'(seg_q.s2oy) - DW'(seg_q.s1oy);
  end

  // cross products
  logic signed [2*DW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic signed [DW-1:0]   d1x2_q, d1y2_q, d1x3_q, d1y3_q;
  logic signed [PW-1:0]   cr_q, cr2_q, num_q;
  logic signed [NW-1:0]   nx_q, ny_q;

  always_ff @(posedge clk_i) begin
    m0_q   <= d1x_q * d2y_q;
    m1_q   <= d1y_q * d2x_q;
    m2_q   <= ex_q * d2y_q;
    m3_q   <= ey_q * d2x_q;
    d1x2_q <= d1x_q;
    d1y2_q <= d1y_q;
    cr_q   <= PW'(m0_q) - PW'(m1_q);
    num_q  <= PW'(m2_q) - PW'(m3_q);
    d1x3_q <= d1x2_q;
    d1y3_q <= d1y2_q;
    nx_q   <= d1x3_q * num_q;
    ny_q   <= d1y3_q * num_q;
    cr2_q  <= cr_q;
  end

  logic signed [QW-1:0] qx, qy;

  sic_div #(.NW(NW), .PW(PW)) u_div_x (
    .clk_i (clk_i),
    .num_i (nx_q),
    .den_i (cr2_q),
    .quo_o (qx)
  );

  sic_div #(.NW(NW), .PW(PW)) u_div_y (
    .clk_i (clk_i),
    .num_i (ny_q),
    .den_i (cr2_q),
    .quo_o (qy)
  );

  // direction angles
  logic signed [ACC_W-1:0] ang1, ang2;

  sic_cordic #(.COORD_BITS(C), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_1 (
    .clk_i (clk_i),
    .dx_i  (d1x_q),
    .dy_i  (d1y_q),
    .ang_o (ang1)
  );

  sic_cordic #(.COORD_BITS(C), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_2 (
    .clk_i (clk_i),
    .dx_i  (d2x_q),
    .dy_i  (d2y_q),
    .ang_o (ang2)
  );

  logic crnz_dly;

  sic_delay #(.W(1), .L(LC - 2)) u_dly_crnz (
    .clk_i (clk_i),
    .d_i   (cr_q != '0),
    .q_o   (crnz_dly)
  );

  logic signed [ACC_W:0] adiff;
  logic [ACC_W:0]        aabs;
  logic                  ok_q, ok_dly;

  always_comb begin
    adiff = (ACC_W+1)'(ang1) - (ACC_W+1)'(ang2);
    aabs  = adiff[ACC_W] ? (ACC_W+1)'(-adiff) : (ACC_W+1)'(adiff);
  end

  always_ff @(posedge clk_i) begin
    ok_q <= crnz_dly && (aabs >= ((ACC_W+1)'(ma_q) << ANGLE_FRAC_BITS));
  end

  sic_delay #(.W(1), .L(T_Q - T_A)) u_dly_ok (
    .clk_i (clk_i),
    .d_i   (ok_q),
    .q_o   (ok_dly)
  );

  seg_t seg_dly;

  sic_delay #(.W($bits(seg_t)), .L(T_Q)) u_dly_seg (
    .clk_i (clk_i),
    .d_i   (seg_q),
    .q_o   (seg_dly)
  );

  // frame check
  logic signed [RXW-1:0] rx, ry;
  logic [RXW-1:0]        rx_u, ry_u;
  logic [XLW-1:0]        wx;
  logic [YLW-1:0]        hy;
  logic                  hit;
  res_t                  res_q, res_dly;
  seg_t                  segf_q;

  always_comb begin
    wx   = (XLW'(fw_q) > XLIM) ? XLIM : XLW'(fw_q);
    hy   = (YLW'(fh_q) > YLIM) ? YLIM : YLW'(fh_q);
    rx   = RXW'(qx) + RXW'(seg_dly.s1ox);
    ry   = RXW'(qy) + RXW'(seg_dly.s1oy);
    rx_u = rx;
    ry_u = ry;
    hit  = ok_dly && !rx[RXW-1] && (rx_u != '0) && (rx_u < RXW'(wx)) &&
           !ry[RXW-1] && (ry_u != '0) && (ry_u < RXW'(hy));
  end

  always_ff @(posedge clk_i) begin
    res_q.ix  <= hit ? rx_u[C-1:0] : '0;
    res_q.iy  <= hit ? ry_u[C-2:0] : '0;
    res_q.fnd <= hit;
    segf_q    <= seg_dly;
  end

  // endpoint distances
  logic signed [DW-1:0]   ddx_q [6];
  logic signed [DW-1:0]   ddy_q [6];
  logic [2*DW-1:0]        sqx_q [6];
  logic [2*DW-1:0]        sqy_q [6];
  logic [SW-1:0]          sum_q [6];
  logic [RB-1:0]          rt    [6];

  always_ff @(posedge clk_i) begin
    ddx_q[0] <= DW'(segf_q.s1ox) - DW'(res_q.ix);
    ddy_q[0] <= DW'(segf_q.s1oy) - DW'(res_q.iy);
    ddx_q[1] <= DW'(segf_q.s1px) - DW'(res_q.ix);
    ddy_q[1] <= DW'(segf_q.s1py) - DW'(res_q.iy);
    ddx_q[2] <= DW'(segf_q.s1px) - DW'(segf_q.s1ox);
    ddy_q[2] <= DW'(segf_q.s1py) - DW'(segf_q.s1oy);
    ddx_q[3] <= DW'(segf_q.s2ox) - DW'(res_q.ix);
    ddy_q[3] <= DW'(segf_q.s2oy) - DW'(res_q.iy);
    ddx_q[4] <= DW'(segf_q.s2px) - DW'(res_q.ix);
    ddy_q[4] <= DW'(segf_q.s2py) - DW'(res_q.iy);
    ddx_q[5] <= DW'(segf_q.s2px) - DW'(segf_q.s2ox);
    ddy_q[5] <= DW'(segf_q.s2py) - DW'(segf_q.s2oy);
    for (int i = 0; i < 6; i++) begin
      sqx_q[i] <= ddx_q[i] * ddx_q[i];
      sqy_q[i] <= ddy_q[i] * ddy_q[i];
      sum_q[i] <= SW'({1'b0, sqx_q[i]} + {1'b0, sqy_q[i]}) << (2 * ROOT_FRAC_BITS);
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_root
    sic_isqrt #(.SW(SW)) u_isqrt (
      .clk_i  (clk_i),
      .v_i    (sum_q[i]),
      .root_o (rt[i])
    );
  end

  sic_delay #(.W($bits(res_t)), .L(RB + 3)) u_dly_res (
    .clk_i (clk_i),
    .d_i   (res_q),
    .q_o   (res_dly)
  );

  // classification
  logic [NEAR_W-1:0]    near;
  logic signed [ES-1:0] e1, e2;
  logic [ES-1:0]        e1a, e2a;
  logic [2:0]           cnt;
  kind_e                kind_d, kind_q;
  res_t                 out_q;

  always_comb begin
    near = NEAR_W'(nd_q) << ROOT_FRAC_BITS;
    e1   = $signed(ES'(rt[0])) + $signed(ES'(rt[1])) - $signed(ES'(rt[2]));
    e2   = $signed(ES'(rt[3])) + $signed(ES'(rt[4])) - $signed(ES'(rt[5]));
    e1a  = e1[ES-1] ? ES'(-e1) : ES'(e1);
    e2a  = e2[ES-1] ? ES'(-e2) : ES'(e2);
    cnt  = 3'(rt[0] < near) + 3'(rt[1] < near) + 3'(rt[3] < near) + 3'(rt[4] < near);
    if (cnt > 3'd3 || e1a > ES'(near) || e2a > ES'(near)) begin
      kind_d = KIND_ERROR;
    end else begin
      kind_d = kind_e'(cnt[1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    out_q  <= res_dly;
  end

  assign result_valid_o = vld_q[NV-1];
  assign cross_x_o      = out_q.ix;
  assign cross_y_o      = out_q.iy;
  assign found_o        = out_q.fnd;
  assign kind_o         = kind_q;

  a_strobe_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, NV))
    else $error("result strobe without a matching input beat");

  a_miss_is_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !found_o |-> cross_x_o == '0 && cross_y_o == '0)
    else $error("point reported without a found intersection");

  a_hit_off_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && found_o |-> cross_x_o != '0 && cross_y_o != '0)
    else $error("found intersection on the frame border");

endmodule

// ===== design/sic_delay.sv =====
// ----------------------------------------------------------------------------
// sic_delay: fixed-length payload delay line
// Carries side data alongside the arithmetic pipelines.
// ----------------------------------------------------------------------------
module sic_delay #(
  parameter int W = 1,
  parameter int L = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [L];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int i = 1; i < L; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[L-1];

endmodule

// ===== design/sic_cordic.sv =====
// ----------------------------------------------------------------------------
// sic_cordic: pipelined vectoring cordic for atan2
// One rotation per stage, result rounded to 2^-ANGLE_FRAC_BITS degree.
// ----------------------------------------------------------------------------
module sic_cordic #(
  parameter int COORD_BITS      = 10,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                             clk_i,
  input  logic signed [COORD_BITS:0]       dx_i,
  input  logic signed [COORD_BITS:0]       dy_i,
  output logic signed [sic_pkg::ACC_W-1:0] ang_o
);
  import sic_pkg::*;

  localparam int PRE = 39 - COORD_BITS;
  localparam int SH  = TAB_FRAC - ANGLE_FRAC_BITS;

  logic signed [CORDIC_W-1:0] x0, y0;
  logic signed [ACC_W-1:0]    a0;
  logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0]    a_q [CORDIC_STEPS+1];
  logic [ACC_W-1:0]           mag, mag_r;
  logic signed [ACC_W-1:0]    ang_d, ang_q;

  always_comb begin
    x0 = CORDIC_W'(dx_i) <<< PRE;
    y0 = CORDIC_W'(dy_i) <<< PRE;
    a0 = '0;
    if (dx_i[COORD_BITS]) begin
      x0 = -x0;
      y0 = -y0;
      a0 = dy_i[COORD_BITS] ? -ACC_HALF_TURN : ACC_HALF_TURN;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= x0;
    y_q[0] <= y0;
    a_q[0] <= a0;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [CORDIC_W-1:0] xs, ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (y_q[k][CORDIC_W-1]) begin
        x_q[k+1] <= x_q[k] - ys;
        y_q[k+1] <= y_q[k] + xs;
        a_q[k+1] <= a_q[k] - atan_entry(k);
      end else if (y_q[k] != '0) begin
        x_q[k+1] <= x_q[k] + ys;
        y_q[k+1] <= y_q[k] - xs;
        a_q[k+1] <= a_q[k] + atan_entry(k);
      end else begin
        x_q[k+1] <= x_q[k];
        y_q[k+1] <= y_q[k];
        a_q[k+1] <= a_q[k];
      end
    end
  end

  // round half away from zero
  always_comb begin
    mag   = a_q[CORDIC_STEPS][ACC_W-1] ? ACC_W'(-a_q[CORDIC_STEPS])
                                       : ACC_W'(a_q[CORDIC_STEPS]);
    mag_r = (mag + (ACC_W'(1) << (SH - 1))) >> SH;
    ang_d = a_q[CORDIC_STEPS][ACC_W-1] ? -$signed(mag_r) : $signed(mag_r);
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
  end

  assign ang_o = ang_q;

endmodule

// ===== design/sic_div.sv =====
// ----------------------------------------------------------------------------
// sic_div: pipelined signed divider with round half to even
// One quotient bit per stage, then sign fix and rounding stages.
// ----------------------------------------------------------------------------
module sic_div #(
  parameter int NW = 34,
  parameter int PW = 23
) (
  input  logic                 clk_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [PW-1:0] den_i,
  output logic signed [NW+1:0] quo_o
);

  localparam int QW = NW + 2;

  logic [NW-1:0] n_q   [NW+1];
  logic [PW:0]   r_q   [NW+1];
  logic [PW-1:0] d_q   [NW+1];
  logic          neg_q [NW+1];

  logic [QW-1:0]        q0;
  logic [PW-1:0]        r0;
  logic signed [QW-1:0] qf_d, qf_q;
  logic [PW-1:0]        rf_d, rf_q, df_q;
  logic                 up;
  logic signed [QW-1:0] quo_q;

  always_ff @(posedge clk_i) begin
    n_q[0]   <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    d_q[0]   <= den_i[PW-1] ? PW'(-den_i) : PW'(den_i);
    r_q[0]   <= '0;
    neg_q[0] <= num_i[NW-1] ^ den_i[PW-1];
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [PW:0] trial;
    logic        take;
    assign trial = {r_q[k][PW-1:0], n_q[k][NW-1]};
    assign take  = trial >= {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      r_q[k+1]   <= take ? trial - {1'b0, d_q[k]} : trial;
      n_q[k+1]   <= {n_q[k][NW-2:0], take};
      d_q[k+1]   <= d_q[k];
      neg_q[k+1] <= neg_q[k];
    end
  end

  // floor quotient and nonnegative remainder
  always_comb begin
    q0 = QW'(n_q[NW]);
    r0 = r_q[NW][PW-1:0];
    if (!neg_q[NW]) begin
      qf_d = q0;
      rf_d = r0;
    end else if (r0 == '0) begin
      qf_d = -q0;
      rf_d = '0;
    end else begin
      qf_d = ~q0;
      rf_d = d_q[NW] - r0;
    end
  end

  always_ff @(posedge clk_i) begin
    qf_q <= qf_d;
    rf_q <= rf_d;
    df_q <= d_q[NW];
  end

  assign up = ({rf_q, 1'b0} > {1'b0, df_q}) ||
              (({rf_q, 1'b0} == {1'b0, df_q}) && qf_q[0]);

  always_ff @(posedge clk_i) begin
    quo_q <= qf_q + QW'(up);
  end

  assign quo_o = quo_q;

endmodule

// ===== design/sic_isqrt.sv =====
// ----------------------------------------------------------------------------
// sic_isqrt: pipelined integer square root
// Exact floor root, one result bit per stage.
// ----------------------------------------------------------------------------
module sic_isqrt #(
  parameter int SW = 29
) (
  input  logic                    clk_i,
  input  logic [SW-1:0]           v_i,
  output logic [(SW+1)/2-1:0]     root_o
);

  localparam int RB = (SW + 1) / 2;
  localparam int VW = 2 * RB;

  logic [RB+1:0] rem_q  [RB];
  logic [RB-1:0] root_q [RB];
  logic [VW-1:0] v_q    [RB];

  for (genvar k = 0; k < RB; k++) begin : g_step
    logic [RB+1:0] rem_in, trial, t;
    logic [RB-1:0] root_in;
    logic [VW-1:0] v_in;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = VW'(v_i);
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = v_q[k-1];
    end
    assign trial = {rem_in[RB-1:0], v_in[VW-1:VW-2]};
    assign t     = {root_in, 2'b01};
    always_ff @(posedge clk_i) begin
      if (trial >= t) begin
        rem_q[k]  <= trial - t;
        root_q[k] <= {root_in[RB-2:0], 1'b1};
      end else begin
        rem_q[k]  <= trial;
        root_q[k] <= {root_in[RB-2:0], 1'b0};
      end
      v_q[k] <= v_in << 2;
    end
  end

  assign root_o = root_q[RB-1];

endmodule

// ===== verif/segment_intersection_classifier_checker.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_classifier_checker: junction predictor and scoreboard
// Tracks the register writes, predicts the point, found flag and kind of every
// accepted segment pair, and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
module segment_intersection_classifier_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  logic [9:0]                     first_start_x_i,
  input  logic [8:0]                     first_start_y_i,
  input  logic [9:0]                     first_end_x_i,
  input  logic [8:0]                     first_end_y_i,
  input  logic [9:0]                     second_start_x_i,
  input  logic [8:0]                     second_start_y_i,
  input  logic [9:0]                     second_end_x_i,
  input  logic [8:0]                     second_end_y_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [sic_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sic_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           result_valid_o,
  input  logic [9:0]                     cross_x_o,
  input  logic [8:0]                     cross_y_o,
  input  logic                           found_o,
  input  logic [1:0]                     kind_o,
  output int                             errors,
  output int                             pending
);
  import sic_pkg::*;

  typedef struct packed {
    logic [9:0] x;
    logic [8:0] y;
    logic       found;
    kind_e      kind;
  } junction_t;

  localparam longint ATAN_DEG [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  logic [FW_W-1:0] frame_w;
  logic [FH_W-1:0] frame_h;
  logic [ND_W-1:0] near_px;
  logic [MA_W-1:0] min_deg;
  junction_t       junctions_due[$];

  // direction angle in 1/256 degree, cordic vectoring
  function automatic longint heading(input longint dx, input longint dy);
    longint acc, x, y, xs, ys, mag;
    acc = 0;
    if (dx < 0) begin
      acc = (dy < 0 ? -180 : 180) * (64'sd1 << 20);
      dx = -dx;
      dy = -dy;
    end
    x = dx * (64'sd1 << 29);
    y = dy * (64'sd1 << 29);
    for (int k = 0; k < 24; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y > 0) begin
        x = x + ys; y = y - xs; acc = acc + ATAN_DEG[k];
      end else if (y < 0) begin
        x = x - ys; y = y + xs; acc = acc - ATAN_DEG[k];
      end
    end
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + (64'sd1 << 11)) >>> 12;
    return (acc < 0) ? -mag : mag;
  endfunction

  // euclidean distance with 4 fraction bits, floored
  function automatic longint span(input longint ax, ay, bx, by);
    longint unsigned v, res, bit_w;
    v = ((ax - bx) * (ax - bx) + (ay - by) * (ay - by)) << 8;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint div_nearest_even(input longint n, input longint d);
    longint q, r;
    if (d < 0) begin
      n = -n; d = -d;
    end
    q = n / d;
    r = n % d;
    if (r < 0) begin
      q--; r += d;
    end
    if (2 * r > d || (2 * r == d && q[0])) q++;
    return q;
  endfunction

  function automatic junction_t predict_junction(input longint o1x, o1y, p1x, p1y,
                                                 input longint o2x, o2y, p2x, p2y);
    junction_t j;
    longint d1x, d1y, d2x, d2y, cr, diff, num, rx, ry, ix, iy, wx, hy, near;
    longint a, b, c, e1, e2;
    int cnt;
    d1x = p1x - o1x; d1y = p1y - o1y;
    d2x = p2x - o2x; d2y = p2y - o2y;
    cr = d1x * d2y - d1y * d2x;
    ix = 0; iy = 0;
    j.found = 1'b0;
    wx = (frame_w > 1024) ? 1024 : frame_w;
    hy = (frame_h > 512) ? 512 : frame_h;
    if (cr != 0) begin
      diff = heading(d1x, d1y) - heading(d2x, d2y);
      if (diff < 0) diff = -diff;
      if (diff >= longint'(min_deg) * 256) begin
        num = (o2x - o1x) * d2y - (o2y - o1y) * d2x;
        rx = o1x + div_nearest_even(d1x * num, cr);
        ry = o1y + div_nearest_even(d1y * num, cr);
        if (rx > 0 && rx < wx && ry > 0 && ry < hy) begin
          ix = rx; iy = ry; j.found = 1'b1;
        end
      end
    end
    near = longint'(near_px) * 16;
    cnt = 0;
    a = span(o1x, o1y, ix, iy);
    b = span(p1x, p1y, ix, iy);
    c = span(p1x, p1y, o1x, o1y);
    e1 = a + b - c;
    if (a < near) cnt++;
    if (b < near) cnt++;
    a = span(o2x, o2y, ix, iy);
    b = span(p2x, p2y, ix, iy);
    c = span(p2x, p2y, o2x, o2y);
    e2 = a + b - c;
    if (a < near) cnt++;
    if (b < near) cnt++;
    if (e1 < 0) e1 = -e1;
    if (e2 < 0) e2 = -e2;
    if (cnt > 3 || e1 > near || e2 > near) cnt = 3;
    j.x = ix[9:0];
    j.y = iy[8:0];
    j.kind = kind_e'(cnt[1:0]);
    return j;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    junction_t want;
    if (!rst_ni) begin
      frame_w <= FW_W'(800);
      frame_h <= FH_W'(448);
      near_px <= ND_W'(50);
      min_deg <= MA_W'(15);
      errors  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRAME_WIDTH:  frame_w <= cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: frame_h <= cfg_data_i[FH_W-1:0];
          CFG_NEAR_DIST:    near_px <= cfg_data_i[ND_W-1:0];
          CFG_MIN_ANGLE:    min_deg <= cfg_data_i[MA_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        junctions_due = {junctions_due, predict_junction(
          first_start_x_i, first_start_y_i, first_end_x_i, first_end_y_i,
          second_start_x_i, second_start_y_i, second_end_x_i, second_end_y_i)};
      end
      if (result_valid_o) begin
        if (junctions_due.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = junctions_due.pop_front();
          if (cross_x_o !== want.x) report_mismatch("cross_x", cross_x_o, want.x);
          if (cross_y_o !== want.y) report_mismatch("cross_y", cross_y_o, want.y);
          if (found_o !== want.found) report_mismatch("found", found_o, want.found);
          if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
        end
      end
    end
    pending = junctions_due.size();
  end

endmodule

// ===== verif/segment_intersection_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_classifier_tb: stimulus and verdict
// Directed junction shapes, then random segment pairs, mostly clustered around
// common points, under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
module segment_intersection_classifier_tb;
  import sic_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd5;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [9:0]            fsx = '0, fex = '0, ssx = '0, sex = '0;
  logic [8:0]            fsy = '0, fey = '0, ssy = '0, sey = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  result_valid_o, found_o;
  logic [9:0]            cross_x_o;
  logic [8:0]            cross_y_o;
  logic [1:0]            kind_o;
  int                    errors, pending, cycles = 0, idle_pct = 0;

  always #10 clk_i = ~clk_i;

  segment_intersection_classifier i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .first_start_x_i(fsx), .first_start_y_i(fsy),
    .first_end_x_i(fex), .first_end_y_i(fey),
    .second_start_x_i(ssx), .second_start_y_i(ssy),
    .second_end_x_i(sex), .second_end_y_i(sey),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .cross_x_o, .cross_y_o, .found_o, .kind_o
  );

  segment_intersection_classifier_checker i_checker (
    .clk_i, .rst_ni, .start, .busy,
    .first_start_x_i(fsx), .first_start_y_i(fsy),
    .first_end_x_i(fex), .first_end_y_i(fey),
    .second_start_x_i(ssx), .second_start_y_i(ssy),
    .second_end_x_i(sex), .second_end_y_i(sey),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .cross_x_o, .cross_y_o, .found_o, .kind_o,
    .errors, .pending
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_intersection_classifier_tb failed");
      $finish;
    end
  end

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  task automatic send_pair(input int ax, ay, bx, by, cx, cy, dx, dy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    fsx <= 10'(ax); fsy <= 9'(ay); fex <= 10'(bx); fey <= 9'(by);
    ssx <= 10'(cx); ssy <= 9'(cy); sex <= 10'(dx); sey <= 9'(dy);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(input int w, h, nd, ang);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_NEAR_DIST, nd);
    write_reg(CFG_MIN_ANGLE, ang);
    @(posedge clk_i);
  endtask

  task automatic random_pairs(input int n);
    int cx, cy, r, pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      cx = $urandom_range(1023);
      cy = $urandom_range(511);
      r = ($urandom_range(3) == 0) ? 400 : 80;
      if (pick < 15) begin
        send_pair($urandom_range(1023), $urandom_range(511), $urandom_range(1023),
                  $urandom_range(511), $urandom_range(1023), $urandom_range(511),
                  $urandom_range(1023), $urandom_range(511));
      end else if (pick < 22) begin
        // parallel copy shifted sideways
        r = $urandom_range(60);
        send_pair(cx, cy, clamp(cx + 100, 1023), clamp(cy + 40, 511),
                  clamp(cx + r, 1023), cy, clamp(cx + r + 100, 1023), clamp(cy + 40, 511));
      end else begin
        // segments around a shared point
        send_pair(clamp(cx + $urandom_range(2 * r) - r, 1023),
                  clamp(cy + $urandom_range(2 * r) - r, 511),
                  clamp(cx + $urandom_range(2 * r) - r, 1023),
                  clamp(cy + $urandom_range(2 * r) - r, 511),
                  clamp(cx + $urandom_range(2 * r) - r, 1023),
                  clamp(cy + $urandom_range(2 * r) - r, 511),
                  clamp(cx + $urandom_range(2 * r) - r, 1023),
                  clamp(cy + $urandom_range(2 * r) - r, 511));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed shapes at reset settings
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(1023, 511, 1023, 511, 1023, 511, 1023, 511);
    send_pair(0, 511, 1023, 0, 0, 0, 1023, 511);
    send_pair(100, 100, 300, 300, 100, 300, 300, 100);
    send_pair(100, 200, 300, 200, 200, 200, 200, 400);
    send_pair(100, 100, 200, 100, 200, 100, 200, 300);
    send_pair(100, 100, 110, 110, 100, 110, 110, 100);
    send_pair(0, 0, 100, 50, 10, 0, 110, 50);
    send_pair(100, 100, 400, 110, 100, 120, 400, 100);
    send_pair(700, 100, 750, 150, 700, 300, 750, 250);
    send_pair(100, 100, 120, 120, 400, 100, 380, 120);
    send_pair(300, 100, 100, 300, 300, 300, 100, 100);
    send_pair(50, 450, 60, 500, 40, 500, 70, 480);
    send_pair(1023, 0, 0, 511, 1023, 511, 0, 0);
    idle_pct = 0;
    random_pairs(120);
    drain();

    setup(2047, 1023, 255, 0);
    write_reg(CFG_UNUSED, 2047);
    idle_pct = 67;
    send_pair(0, 0, 1023, 511, 0, 511, 1023, 0);
    random_pairs(60);
    drain();
    random_pairs(60);
    drain();

    setup(0, 0, 0, 255);
    idle_pct = 15;
    send_pair(100, 100, 300, 300, 100, 300, 300, 100);
    random_pairs(20);
    drain();

    setup(1, 1, 1, 180);
    random_pairs(15);
    drain();

    setup(1024, 512, 30, 5);
    random_pairs(160);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("segment_intersection_classifier_tb passed");
    end else begin
      $display("segment_intersection_classifier_tb failed");
    end
    $finish;
  end

endmodule

// ===== segment_intersection_classifier.f =====
design/sic_pkg.sv
design/sic_delay.sv
design/sic_cordic.sv
design/sic_div.sv
design/sic_isqrt.sv
design/segment_intersection_classifier.sv
verif/segment_intersection_classifier_checker.sv
verif/segment_intersection_classifier_tb.sv
